@@ rtl/asc128_pkg.sv @@
// Shared types, constants and round functions for the Ascon-128 empty-message tag unit.
// Depends on nothing; every other file of the block refers to it by scoped names.
package asc128_pkg;

   // Permutation geometry: one round per pipeline stage, two permutations.
   localparam int PaRounds  = 12;
   localparam int PipeDepth = 2 * PaRounds;
   localparam int WordBits  = 64;

   // Initialization vector and the two single-bit constants of finalization.
   localparam logic [63:0] AsconIv   = 64'h80400c0600000000;
   localparam logic [63:0] DomainBit = 64'h0000000000000001;
   localparam logic [63:0] PadBit    = 64'h8000000000000000;

   // Round constants, entry 0 is used by the first round.
   localparam logic [PaRounds-1:0][7:0] RcTable = {
      8'h4b, 8'h5a, 8'h69, 8'h78, 8'h87, 8'h96,
      8'ha5, 8'hb4, 8'hc3, 8'hd2, 8'he1, 8'hf0
   };

   typedef logic [WordBits-1:0] word_type;

   // Five 64-bit words; word 0 is index 0.
   typedef logic [4:0][WordBits-1:0] state_type;

   // Key as held by the configuration registers.
   typedef struct packed {
      word_type high;
      word_type low;
   } key_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      KeyHighIdx = 1'b0,
      KeyLowIdx  = 1'b1
   } csr_index_type;

   function automatic word_type rotr(word_type v, int unsigned n);
      return (v >> n) | (v << (WordBits - n));
   endfunction

   // One round: constant addition, substitution layer and linear diffusion.
   function automatic state_type perm_round(state_type s, logic [7:0] rc);
      word_type a, b, m, d, e;
      word_type na, nb, nm, nd, ne;
      state_type r;
      a = s[0];
      b = s[1];
      m = s[2] ^ {56'd0, rc};
      d = s[3];
      e = s[4];
      a = a ^ e;
      e = e ^ d;
      m = m ^ b;
      na = ~a & b;
      nb = ~b & m;
      nm = ~m & d;
      nd = ~d & e;
      ne = ~e & a;
      a = a ^ nb;
      b = b ^ nm;
      m = m ^ nd;
      d = d ^ ne;
      e = e ^ na;
      b = b ^ a;
      a = a ^ e;
      d = d ^ m;
      m = ~m;
      r[0] = a ^ rotr(a, 19) ^ rotr(a, 28);
      r[1] = b ^ rotr(b, 61) ^ rotr(b, 39);
      r[2] = m ^ rotr(m, 1) ^ rotr(m, 6);
      r[3] = d ^ rotr(d, 10) ^ rotr(d, 17);
      r[4] = e ^ rotr(e, 7) ^ rotr(e, 41);
      return r;
   endfunction

   // Initial state from the key and the nonce.
   function automatic state_type load_state(key_type key, word_type nh, word_type nl);
      state_type r;
      r[0] = AsconIv;
      r[1] = key.high;
      r[2] = key.low;
      r[3] = nh;
      r[4] = nl;
      return r;
   endfunction

   // Between the permutations: key after initialization, empty-block padding,
   // domain separation and the finalization key.
   function automatic state_type bridge_state(state_type s, key_type key);
      state_type r;
      r[0] = s[0] ^ PadBit;
      r[1] = s[1] ^ key.high;
      r[2] = s[2] ^ key.low;
      r[3] = s[3] ^ key.high;
      r[4] = s[4] ^ key.low ^ DomainBit;
      return r;
   endfunction

endpackage

@@ rtl/asc128_if.sv @@
// Valid/ready channel interfaces for nonce requests and tag responses.
// Depends on asc128_pkg for the word type.
interface asc128_req_if;
   logic                 valid;
   logic                 ready;
   asc128_pkg::word_type nonce_high;
   asc128_pkg::word_type nonce_low;

   modport source (output valid, output nonce_high, output nonce_low, input ready);
   modport sink (input valid, input nonce_high, input nonce_low, output ready);
endinterface

interface asc128_rsp_if;
   logic                 valid;
   logic                 ready;
   asc128_pkg::word_type tag_high;
   asc128_pkg::word_type tag_low;

   modport source (output valid, output tag_high, output tag_low, input ready);
   modport sink (input valid, input tag_high, input tag_low, output ready);
endinterface

@@ rtl/asc128_key_regs.sv @@
// Key configuration registers written through the plain write port.
// Depends on asc128_pkg for the key type and register indexes.
module asc128_key_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [0:0]           csr_index,
   input  asc128_pkg::word_type csr_write_data,
   output asc128_pkg::key_type  key
);

   asc128_pkg::key_type key_ff, key_in;

   // Decode the register index and replace the addressed key half.
   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         unique case (asc128_pkg::csr_index_type'(csr_index))
            asc128_pkg::KeyHighIdx: key_in.high = csr_write_data;
            asc128_pkg::KeyLowIdx:  key_in.low  = csr_write_data;
            default:                key_in      = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

@@ rtl/asc128_round_stage.sv @@
// One pipeline stage: a single permutation round and its state register.
// Depends on asc128_pkg for the state type and the round function.
module asc128_round_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  asc128_pkg::state_type in_state,
   input  logic [7:0]            rc,
   output logic                  out_valid,
   output asc128_pkg::state_type out_state
);

   logic                  valid_ff, valid_in;
   asc128_pkg::state_type state_ff, state_in;

   // The round itself; the register holds its value while the pipeline stalls.
   always_comb begin
      valid_in = advance ? in_valid : valid_ff;
      state_in = advance ? asc128_pkg::perm_round(in_state, rc) : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

@@ rtl/ascon128_empty_message_tag_unit.sv @@
// Top level of the Ascon-128 empty-message tag unit: key registers and round pipeline.
// Depends on asc128_pkg, asc128_if, asc128_key_regs and asc128_round_stage.
//
// Usage:
// The key is written through the csr_ port, index 0 for the first eight key
// bytes and index 1 for the last eight, while no nonce is in flight. Each
// beat on the req_bus channel carries a 128-bit nonce; each beat on the
// rsp_bus channel returns its 128-bit tag, in the order the nonces came in.
// The datapath is a pipeline of 24 stages, one permutation round each; the
// key additions, padding and domain bit sit in front of the first round of
// the second permutation and at the tag output. A tag is offered while its
// state sits in the last stage, and one nonce is taken every cycle unless
// a tag waits at the output. If the receiver holds rsp_bus.ready low while
// a tag is offered, the whole pipeline freezes and req_bus.ready drops with
// it; the empty stages keep filling only while the last stage can move.
// Synchronous reset clears the key to zero and empties the pipeline.
module ascon128_empty_message_tag_unit (
   input  logic                 clock,
   input  logic                 reset,
   asc128_req_if.sink           req_bus,
   asc128_rsp_if.source         rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [0:0]           csr_index,
   input  asc128_pkg::word_type csr_write_data
);

   localparam int Depth  = asc128_pkg::PipeDepth;
   localparam int Rounds = asc128_pkg::PaRounds;

   asc128_pkg::key_type   key;
   asc128_pkg::state_type stage_state [Depth];
   logic [Depth-1:0]      stage_valid;
   logic                  advance;

   asc128_key_regs u_key_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .key              (key)
   );

   // The pipeline moves as one whenever the last stage is empty or drained.
   assign advance       = !stage_valid[Depth-1] || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Round stages; the first round of each permutation gets its own feed.
   for (genvar i = 0; i < Depth; i++) begin : g_stage
      asc128_pkg::state_type feed_state;
      logic                  feed_valid;

      if (i == 0) begin : g_load
         assign feed_state = asc128_pkg::load_state(key, req_bus.nonce_high,
                                                    req_bus.nonce_low);
         assign feed_valid = req_bus.valid;
      end else if (i == Rounds) begin : g_bridge
         assign feed_state = asc128_pkg::bridge_state(stage_state[i-1], key);
         assign feed_valid = stage_valid[i-1];
      end else begin : g_chain
         assign feed_state = stage_state[i-1];
         assign feed_valid = stage_valid[i-1];
      end

      asc128_round_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (feed_valid),
         .in_state  (feed_state),
         .rc        (asc128_pkg::RcTable[i % Rounds]),
         .out_valid (stage_valid[i]),
         .out_state (stage_state[i])
      );
   end

   // The tag is the last two words with the key added once more.
   assign rsp_bus.valid    = stage_valid[Depth-1];
   assign rsp_bus.tag_high = stage_state[Depth-1][3] ^ key.high;
   assign rsp_bus.tag_low  = stage_state[Depth-1][4] ^ key.low;

endmodule

@@ rtl/asc128_checker.sv @@
// Port-level checker for the Ascon-128 empty-message tag unit, bound to its top level.
// Depends on asc128_pkg for the pipeline depth and the word type.
module asc128_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input asc128_pkg::word_type rsp_tag_high,
   input asc128_pkg::word_type rsp_tag_low
);

   localparam int Depth = asc128_pkg::PipeDepth;
   localparam int CountBits = $clog2(Depth + 1);

   logic [CountBits-1:0] in_flight_ff, in_flight_in;
   logic                 req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Nonces taken but whose tags are not yet delivered.
   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_beat && !rsp_beat) begin
         in_flight_in = in_flight_ff + CountBits'(1);
      end else if (rsp_beat && !req_beat) begin
         in_flight_in = in_flight_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // No more nonces in flight than the pipeline has stages.
   a_bounded_flight: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= CountBits'(Depth))
      else $error("more nonces in flight than pipeline stages");

   // A tag is offered only for a nonce that was taken.
   a_no_invented_tag: assert property (@(posedge clock) disable iff (reset)
      (in_flight_ff == '0) |-> !rsp_valid)
      else $error("tag offered with no nonce in flight");

   // The input side stalls exactly when a tag waits at the output.
   a_stall_coupling: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output stall");

   // A stalled tag holds its value.
   a_tag_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_tag_high) && $stable(rsp_tag_low)))
      else $error("stalled tag changed or vanished");

endmodule

bind ascon128_empty_message_tag_unit asc128_checker u_asc128_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_tag_high (rsp_bus.tag_high),
   .rsp_tag_low  (rsp_bus.tag_low)
);
